// ===== hdl/u8cci_pkg.sv =====
package u8cci_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 32;
  localparam int CP_WIDTH            = 21;
  localparam int CFG_ADDR_WIDTH      = 3;

  // Lookup status codes
  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_RANGE   = 2'd1,
    ST_INVALID = 2'd2
  } lookup_status_t;

  // Configuration register byte addresses
  localparam logic [CFG_ADDR_WIDTH-1:0] ADDR_TARGET_INDEX = 3'd0;

  // Decoded lead byte
  typedef struct packed {
    logic       valid;
    logic [1:0] extra;
    logic [6:0] payload;
  } lead_t;

  function automatic lead_t decode_lead(input logic [7:0] b);
    lead_t d;
    d.valid   = 1'b1;
    d.extra   = 2'd0;
    d.payload = 7'd0;
    if ((b & 8'h80) == 8'h00) begin
      d.payload = b[6:0];
    end else if ((b & 8'hE0) == 8'hC0) begin
      d.payload = {2'b00, b[4:0]};
      d.extra   = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      d.payload = {3'b000, b[3:0]};
      d.extra   = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      d.payload = {4'b0000, b[2:0]};
      d.extra   = 2'd3;
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== hdl/utf8_codepoint_count_and_index.sv =====
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   data_byte[7:0], last_byte
// result    out        out_valid/out_stall codepoint_count[31:0], lookup_status[1:0],
//                                          codepoint_value[20:0]
// config    in         APB write           paddr[2:0], pwdata[31:0] (target_index at 0x0)
//
// One byte is taken per clock while in_stall is low; the stream state updates at the edge that accepts it.
// The result of a string is registered and appears in the cycle after its last byte is accepted.
// The single result register sets the rate: input stalls only while a result is held
// and the result side stalls too, so bytes keep flowing as long as results drain.
// rst is synchronous and active high; it clears the stream state, the result valid
// and target_index.
module utf8_codepoint_count_and_index #(
  parameter int COUNT_WIDTH = u8cci_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // byte stream
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          data_byte,
  input  logic                                last_byte,
  // per-string result
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [31:0]                         codepoint_count,
  output logic [1:0]                          lookup_status,
  output logic [u8cci_pkg::CP_WIDTH-1:0]      codepoint_value,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [u8cci_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import u8cci_pkg::*;

  // Compare width covers both the count and the 32-bit index
  localparam int CMP_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [31:0]             target_index;

  // Stream state
  logic [1:0]              bytes_remaining, bytes_remaining_next;
  logic [CP_WIDTH-1:0]     partial_codepoint, partial_codepoint_next;
  logic [COUNT_WIDTH-1:0]  count_so_far, count_so_far_next;
  logic                    lookup_done, lookup_done_next;
  lookup_status_t          result_status, result_status_next;
  logic [CP_WIDTH-1:0]     found_codepoint, found_codepoint_next;
  logic                    capture_active, capture_active_next;

  logic                    in_accept;
  logic                    out_take;
  lead_t                   lead;
  logic [CMP_W-1:0]        count_ext;
  logic [31:0]             count_sat;
  lookup_status_t          status_final;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, one register
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_index <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == ADDR_TARGET_INDEX[2])) begin
      target_index <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == ADDR_TARGET_INDEX[2]) begin
      prdata = target_index;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes: a held result stalls input only while the result side stalls
  // ---------------------------------------------------------------------------
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign lead = decode_lead(data_byte);

  // ---------------------------------------------------------------------------
  // Per-byte update of the stream state
  // ---------------------------------------------------------------------------
  always_comb begin
    bytes_remaining_next   = bytes_remaining;
    partial_codepoint_next = partial_codepoint;
    count_so_far_next      = count_so_far;
    lookup_done_next       = lookup_done;
    result_status_next     = result_status;
    found_codepoint_next   = found_codepoint;
    capture_active_next    = capture_active;

    if (bytes_remaining != 2'd0) begin
      // Continuation: shift in the low six bits, no check on the top bits
      partial_codepoint_next = {partial_codepoint[CP_WIDTH-7:0], data_byte[5:0]};
      if (capture_active) begin
        found_codepoint_next = partial_codepoint_next;
      end
      bytes_remaining_next = bytes_remaining - 2'd1;
      if (bytes_remaining_next == 2'd0) begin
        capture_active_next = 1'b0;
      end
    end else begin
      // Lead byte (or a stray byte that counts as one codepoint)
      if (count_so_far != COUNT_MAX) begin
        count_so_far_next = count_so_far + 1'b1;
      end
      if (!lookup_done) begin
        if (!lead.valid) begin
          lookup_done_next   = 1'b1;
          result_status_next = ST_INVALID;
        end else if (CMP_W'(count_so_far) == CMP_W'(target_index)) begin
          lookup_done_next     = 1'b1;
          result_status_next   = ST_FOUND;
          found_codepoint_next = CP_WIDTH'(lead.payload);
          capture_active_next  = (lead.extra != 2'd0);
        end
      end
      partial_codepoint_next = CP_WIDTH'(lead.payload);
      bytes_remaining_next   = lead.extra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_accept && last_byte)) begin
      // Clear at reset and at the end of every string
      bytes_remaining   <= '0;
      partial_codepoint <= '0;
      count_so_far      <= '0;
      lookup_done       <= 1'b0;
      result_status     <= ST_RANGE;
      found_codepoint   <= '0;
      capture_active    <= 1'b0;
    end else if (in_accept) begin
      bytes_remaining   <= bytes_remaining_next;
      partial_codepoint <= partial_codepoint_next;
      count_so_far      <= count_so_far_next;
      lookup_done       <= lookup_done_next;
      result_status     <= result_status_next;
      found_codepoint   <= found_codepoint_next;
      capture_active    <= capture_active_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result formation: saturate the count to 32 bits, default to out of range
  // ---------------------------------------------------------------------------
  assign count_ext    = CMP_W'(count_so_far_next);
  assign count_sat    = (count_ext > CMP_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : count_ext[31:0];
  assign status_final = lookup_done_next ? result_status_next : ST_RANGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload registers: load on the last byte, hold otherwise
  always_ff @(posedge clk) begin
    if (in_accept && last_byte) begin
      codepoint_count <= count_sat;
      lookup_status   <= status_final;
      codepoint_value <= (status_final == ST_FOUND) ? found_codepoint_next : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && last_byte |=> out_valid)
    else $error("last byte accepted but no result");

  a_value_zero_unless_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (lookup_status != ST_FOUND) |-> codepoint_value == '0)
    else $error("codepoint value nonzero without a found status");

  a_capture_consistent: assert property (@(posedge clk) disable iff (rst)
    capture_active |-> lookup_done && (result_status == ST_FOUND) && (bytes_remaining != 2'd0))
    else $error("capture active outside a found sequence");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lookup_status == ST_FOUND) || (lookup_status == ST_RANGE) ||
                  (lookup_status == ST_INVALID))
    else $error("illegal status code on result");

endmodule
